// File: rtl/core/hns_pkg.sv
`timescale 1ns / 1ps
package hns_pkg;

  localparam int CFG_W             = 13;
  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int MIN_WIDTH         = 2;
  localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 13'd640;

  // Result queue between the datapath and the output port.
  localparam int BUF_DEPTH = 4;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int BUF_CW    = $clog2(BUF_DEPTH + 1);

  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       row_end;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[8:1];
  endfunction

  function automatic result_t smooth(input pixel_t a, input pixel_t b,
                                     input logic row_end, input logic run_last);
    result_t r;
    r.out_red   = avg8(a.in_red, b.in_red);
    r.out_green = avg8(a.in_green, b.in_green);
    r.out_blue  = avg8(a.in_blue, b.in_blue);
    r.row_end   = row_end;
    r.run_last  = run_last;
    return r;
  endfunction

endpackage

// File: rtl/core/hns_datapath.sv
`timescale 1ns / 1ps
module hns_datapath import hns_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  pixel_t           pixel,
  input  logic [CFG_W-1:0] row_width,
  output push_t            push
);

  localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W = ((CFG_W > COL_W) ? CFG_W : COL_W) + 1;

  logic [COL_W-1:0] col;
  pixel_t           prev;
  pixel_t           older;

  logic [CMP_W-1:0] rw_ext;
  logic [CMP_W-1:0] w_eff;
  logic             last;
  pixel_t           left;

  always_comb begin
    rw_ext = CMP_W'(row_width);
    if (rw_ext < CMP_W'(MIN_WIDTH)) begin
      w_eff = CMP_W'(MIN_WIDTH);
    end else if (rw_ext > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = rw_ext;
    end
    // A column at or past the end, also after a width change mid-row, closes the row.
    last = CMP_W'(col) >= (w_eff - CMP_W'(1));
    left = (col == COL_W'(1)) ? prev : older;

    if (col == '0) begin
      push.count = PUSH_NONE;
    end else if (last) begin
      push.count = PUSH_TWO;
    end else begin
      push.count = PUSH_ONE;
    end
    push.first  = smooth(left, pixel, 1'b0, !last);
    push.second = smooth(pixel, prev, 1'b1, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (advance) begin
      col <= last ? '0 : col + COL_W'(1);
    end
  end

  // The pixel history is only read once the column count shows it was written.
  always_ff @(posedge clk) begin
    if (advance) begin
      older <= prev;
      prev  <= pixel;
    end
  end

endmodule

// File: rtl/core/hns_out_buf.sv
`timescale 1ns / 1ps
module hns_out_buf import hns_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  push_t             push,
  output logic [BUF_CW-1:0] free,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           out_result
);

  result_t           mem [BUF_DEPTH];
  logic [BUF_AW-1:0] wr_ptr;
  logic [BUF_AW-1:0] rd_ptr;
  logic [BUF_CW-1:0] count;
  logic [1:0]        wr_n;
  logic              pop;

  assign wr_n       = advance ? push.count : PUSH_NONE;
  assign pop        = out_valid && out_ready;
  assign out_valid  = count != '0;
  assign out_result = mem[rd_ptr];
  assign free       = BUF_CW'(BUF_DEPTH) - count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + BUF_AW'(wr_n);
      rd_ptr <= rd_ptr + BUF_AW'(pop);
      count  <= count + BUF_CW'(wr_n) - BUF_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_n != PUSH_NONE) begin
      mem[wr_ptr] <= push.first;
    end
    if (wr_n == PUSH_TWO) begin
      mem[wr_ptr + BUF_AW'(1)] <= push.second;
    end
  end

endmodule

// File: rtl/core/horizontal_neighbour_smoothing_core.sv
`timescale 1ns / 1ps
// Horizontal smoothing of an RGB pixel stream in raster order.
// Input channel: in_valid/in_ready with one pixel per request. Output channel:
// out_valid/out_ready with one smoothed pixel per request, flagged with row_end
// and run_last. cfg_we/cfg_data write the row width (clamped to 2..MAX_WIDTH);
// write it only while the block is idle.
// Each request first lands in an input register; once the queue has room, its results
// (none for the first pixel of a row, two for the last, one otherwise) move
// into a four-entry result queue and are offered on the output the cycle after.
// The stream itself lags one pixel: a pixel's result leaves with the next pixel.
// Throughput is one request per clock; the extra result at each row end is
// absorbed by the queue as long as the receiver takes one result per clock.
// When the receiver stalls, the queue fills, the input register holds its
// pixel, and in_ready drops until the queue has room for that pixel's results.
// Reset (rst, synchronous) empties the queue, restarts the column count at
// zero and sets the row width to 640.
module horizontal_neighbour_smoothing_core import hns_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pixel_t           in_pixel,
  output logic             out_valid,
  input  logic             out_ready,
  output result_t          out_result,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  logic              in_valid_q;
  pixel_t            pixel_q;
  logic [CFG_W-1:0]  row_width;
  logic              advance;
  push_t             push;
  logic [BUF_CW-1:0] free;

  assign advance  = in_valid_q && (free >= BUF_CW'(push.count));
  assign in_ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      row_width  <= ROW_WIDTH_RESET;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid;
      end
      if (cfg_we) begin
        row_width <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pixel_q <= in_pixel;
    end
  end

  hns_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .pixel     (pixel_q),
    .row_width (row_width),
    .push      (push)
  );

  hns_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .push       (push),
    .free       (free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  // A pixel held back by a full queue stays in the input register.
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !advance |=> in_valid_q && $stable(pixel_q))
    else $error("stalled pixel lost or changed");

  // A row end yields a continuing result followed by the closing one.
  a_row_end_pair: assert property (@(posedge clk) disable iff (rst)
    advance && push.count == PUSH_TWO |->
      !push.first.run_last && !push.first.row_end && push.second.row_end)
    else $error("row end results out of order");

  // Anything pushed is offered on the output in the next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    advance && push.count != PUSH_NONE |=> out_valid)
    else $error("pushed result not offered");

  // The queue never overflows.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    advance |-> free >= BUF_CW'(push.count))
    else $error("result queue overflow");

endmodule
